// File: rtl/jsbd_pkg.sv
`default_nettype none

package jsbd_pkg;

  typedef enum logic [2:0] {
    StPending = 3'd0,
    StOk      = 3'd1,
    StCtrl    = 3'd2,
    StEscape  = 3'd3,
    StLong    = 3'd4,
    StUtf8    = 3'd5,
    StUnterm  = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       body_ended;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       done_res;
    status_e    status;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  cont_left;
    logic [2:0]  seq_len;
    logic [20:0] acc;
    logic        fault;
  } utf8_state_t;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChBs        = 8'h08;
  localparam logic [7:0] ChFf        = 8'h0C;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;

  localparam logic [20:0] CpMin2    = 21'h80;
  localparam logic [20:0] CpMin3    = 21'h800;
  localparam logic [20:0] CpMin4    = 21'h10000;
  localparam logic [20:0] CpMax     = 21'h10FFFF;
  localparam logic [20:0] SurrLow   = 21'hD800;
  localparam logic [20:0] SurrHigh  = 21'hDFFF;

endpackage

`default_nettype wire

// File: rtl/jsbd_utf8.sv
`default_nettype none

module jsbd_utf8 (
  input  jsbd_pkg::utf8_state_t state_i,
  input  logic [7:0]            byte_i,
  output jsbd_pkg::utf8_state_t state_o
);

  logic [20:0] acc_shift;
  logic        cp_bad;

  assign acc_shift = {state_i.acc[14:0], byte_i[5:0]};

  always_comb begin
    cp_bad = ((state_i.seq_len == 3'd2) && (acc_shift < jsbd_pkg::CpMin2)) ||
             ((state_i.seq_len == 3'd3) && (acc_shift < jsbd_pkg::CpMin3)) ||
             ((state_i.seq_len == 3'd4) && (acc_shift < jsbd_pkg::CpMin4)) ||
             (acc_shift > jsbd_pkg::CpMax) ||
             ((acc_shift >= jsbd_pkg::SurrLow) && (acc_shift <= jsbd_pkg::SurrHigh));
  end

  always_comb begin
    state_o = state_i;
    if (!state_i.fault) begin
      if (state_i.cont_left == 2'd0) begin
        if (byte_i[7] == 1'b0) begin
          state_o = state_i;
        end else if (byte_i[7:5] == 3'b110) begin
          state_o.seq_len   = 3'd2;
          state_o.acc       = {16'd0, byte_i[4:0]};
          state_o.cont_left = 2'd1;
        end else if (byte_i[7:4] == 4'b1110) begin
          state_o.seq_len   = 3'd3;
          state_o.acc       = {17'd0, byte_i[3:0]};
          state_o.cont_left = 2'd2;
        end else if (byte_i[7:3] == 5'b11110) begin
          state_o.seq_len   = 3'd4;
          state_o.acc       = {18'd0, byte_i[2:0]};
          state_o.cont_left = 2'd3;
        end else begin
          state_o.fault = 1'b1;
        end
      end else if (byte_i[7:6] != 2'b10) begin
        state_o.fault     = 1'b1;
        state_o.cont_left = 2'd0;
      end else if (state_i.cont_left == 2'd1) begin
        state_o.cont_left = 2'd0;
        state_o.fault     = cp_bad;
        state_o.seq_len   = 3'd0;
        state_o.acc       = 21'd0;
      end else begin
        state_o.cont_left = state_i.cont_left - 2'd1;
        state_o.acc       = acc_shift;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/json_string_body_decoder_core.sv
// Decodes the body of a JSON string, one raw byte per input word, and checks
// the decoded bytes as UTF-8.
// The input channel carries the raw byte and an end-of-input flag; each
// accepted input word yields exactly one result word on the output channel.
// A result carries the appended decoded byte, a verdict that ends the string
// and clears the string state for the next one, or neither for a backslash.
// The configuration channel writes the maximum decoded length; it is always
// ready and should be written only while the block is idle.
// The word is captured in the input register when it is accepted, and the
// result register is loaded from it when the result register may advance.
// Throughput is one word per cycle while the receiver does not stall; the
// state update runs combinationally between the input and result registers.
// Reset empties both registers, clears the string state and sets the maximum
// length to 4096.
// When the receiver stalls, the result is held; the input register still takes
// one word if it is empty, after which the input channel stalls as well.
`default_nettype none

module json_string_body_decoder_core #(
  parameter int LENGTH_BITS = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  jsbd_pkg::in_word_t       in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output jsbd_pkg::out_word_t      out_word_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [LENGTH_BITS-1:0]   cfg_data_i
);

  localparam logic [LENGTH_BITS-1:0] MaxLenReset = LENGTH_BITS'(32'd4096);

  logic [LENGTH_BITS-1:0] max_len_q;
  logic                   s1_valid_q;
  jsbd_pkg::in_word_t     s1_word_q;
  logic                   out_valid_q;
  jsbd_pkg::out_word_t    out_word_q, out_word_d;

  logic                   esc_q, esc_d;
  logic [LENGTH_BITS:0]   count_q, count_d;
  jsbd_pkg::utf8_state_t  utf_q, utf_d, utf_fed;

  logic                   adv_out;
  logic                   fire;
  logic [7:0]             dec;
  logic                   append;
  logic                   esc_bad;
  logic [LENGTH_BITS:0]   count_inc;

  assign adv_out     = !out_valid_q || !out_stall_i;
  assign fire        = s1_valid_q && adv_out;
  assign in_stall_o  = s1_valid_q && !adv_out;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign count_inc   = count_q + (LENGTH_BITS+1)'(1'b1);

  jsbd_utf8 u_utf8 (
    .state_i (utf_q),
    .byte_i  (dec),
    .state_o (utf_fed)
  );

  always_comb begin
    esc_bad = 1'b0;
    case (s1_word_q.in_byte)
      jsbd_pkg::ChQuote:     dec = jsbd_pkg::ChQuote;
      jsbd_pkg::ChBackslash: dec = jsbd_pkg::ChBackslash;
      jsbd_pkg::ChSlash:     dec = jsbd_pkg::ChSlash;
      jsbd_pkg::ChB:         dec = jsbd_pkg::ChBs;
      jsbd_pkg::ChF:         dec = jsbd_pkg::ChFf;
      jsbd_pkg::ChN:         dec = jsbd_pkg::ChLf;
      jsbd_pkg::ChR:         dec = jsbd_pkg::ChCr;
      jsbd_pkg::ChT:         dec = jsbd_pkg::ChTab;
      default: begin
        dec     = s1_word_q.in_byte;
        esc_bad = esc_q;
      end
    endcase
    if (!esc_q) begin
      dec = s1_word_q.in_byte;
    end
  end

  always_comb begin
    esc_d      = esc_q;
    count_d    = count_q;
    utf_d      = utf_q;
    append     = 1'b0;
    out_word_d = '{out_byte: 8'd0, out_valid: 1'b0, done_res: 1'b1,
                   status: jsbd_pkg::StPending};
    if (s1_word_q.body_ended) begin
      out_word_d.status = jsbd_pkg::StUnterm;
    end else if (esc_q) begin
      esc_d = 1'b0;
      if (esc_bad) begin
        out_word_d.status = jsbd_pkg::StEscape;
      end else begin
        append = 1'b1;
      end
    end else if (s1_word_q.in_byte == jsbd_pkg::ChQuote) begin
      out_word_d.status = (utf_q.fault || (utf_q.cont_left != 2'd0)) ?
                          jsbd_pkg::StUtf8 : jsbd_pkg::StOk;
    end else if (s1_word_q.in_byte < jsbd_pkg::ChSpace) begin
      out_word_d.status = jsbd_pkg::StCtrl;
    end else if (s1_word_q.in_byte == jsbd_pkg::ChBackslash) begin
      esc_d               = 1'b1;
      out_word_d.done_res = 1'b0;
    end else begin
      append = 1'b1;
    end

    if (append) begin
      if (count_inc > {1'b0, max_len_q}) begin
        out_word_d.status = jsbd_pkg::StLong;
      end else begin
        count_d    = count_inc;
        utf_d      = utf_fed;
        out_word_d = '{out_byte: dec, out_valid: 1'b1, done_res: 1'b0,
                       status: jsbd_pkg::StPending};
      end
    end

    if (out_word_d.done_res) begin
      esc_d   = 1'b0;
      count_d = '0;
      utf_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MaxLenReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      esc_q       <= 1'b0;
      count_q     <= '0;
      utf_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_data_i;
      end
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv_out) begin
        out_valid_q <= s1_valid_q;
      end
      if (fire) begin
        esc_q   <= esc_d;
        count_q <= count_d;
        utf_q   <= utf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_word_q <= in_word_i;
    end
    if (fire) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/jsbd_checker.sv
`default_nettype none

module jsbd_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input jsbd_pkg::out_word_t  out_word_o
);

  // A stalled result word stays presented and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled result word changed");

  // A word without an appended byte carries a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.out_valid) |-> (out_word_o.out_byte == 8'd0))
    else $error("nonzero byte without append");

  // A verdict never appends a byte and never reports pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.done_res) |->
      (!out_word_o.out_valid && (out_word_o.status != jsbd_pkg::StPending)))
    else $error("bad verdict word");

  // A word that is not a verdict reports pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.done_res) |-> (out_word_o.status == jsbd_pkg::StPending))
    else $error("non-verdict word with final status");

endmodule

bind json_string_body_decoder_core jsbd_checker u_jsbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
